// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the request planner checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TFRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define TFRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/tfrp_pkg.sv
// ----------------------------------------------------------------------------
// tfrp_pkg
// shared constants, codes and types of the three floor request planner
// ----------------------------------------------------------------------------
package tfrp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int POS_W      = 10;
    localparam int MARGIN_W   = 8;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_CALL_ONE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CALL_THREE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP_PRESS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STOP_FREE  = 3'd5;

    // floor codes held in the queue
    localparam logic [1:0] FLOOR_ONE = 2'd0;
    localparam logic [1:0] FLOOR_TWO = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MARGIN = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_SERVE
    } t_state;

    typedef struct packed {
        logic latch;
        logic apply_event;
        logic serve;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic door_open;
        logic queue_nonempty;
    } t_dp_status;

endpackage

// File: src/tfrp_ctrl.sv
// ----------------------------------------------------------------------------
// tfrp_ctrl
// sequencer: latch, event phase, serve phase with result strobe
// ----------------------------------------------------------------------------
module tfrp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tfrp_pkg::t_dp_status i_status,
    output tfrp_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);

    tfrp_pkg::t_state r_state;
    tfrp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tfrp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = tfrp_pkg::ST_EVENT;
                end
            end
            tfrp_pkg::ST_EVENT: n_state = tfrp_pkg::ST_SERVE;
            tfrp_pkg::ST_SERVE: n_state = tfrp_pkg::ST_IDLE;
            default:            n_state = tfrp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            tfrp_pkg::ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            tfrp_pkg::ST_EVENT: begin
                // doors open freezes the planner state (queue, pending flags, stop hold and target)
                o_cmd.apply_event = !i_status.door_open;
            end
            tfrp_pkg::ST_SERVE: begin
                o_cmd.serve = !i_status.door_open && i_status.queue_nonempty;
                o_cmd.emit  = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// File: src/tfrp_datapath.sv
// ----------------------------------------------------------------------------
// tfrp_datapath
// config registers, circular request queue, pending flags and result register
// ----------------------------------------------------------------------------
module tfrp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfrp_pkg::t_dp_cmd                   i_cmd,
    output tfrp_pkg::t_dp_status                o_status,
    input  logic [tfrp_pkg::KIND_W-1:0]         i_kind,
    input  logic [tfrp_pkg::POS_W-1:0]          i_car_position,
    input  logic                                i_door_open,
    input  logic                                i_cfg_we,
    input  logic [tfrp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tfrp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic [tfrp_pkg::POS_W-1:0]          o_target_position,
    output logic                                o_target_update,
    output logic                                o_motor_stop,
    output logic                                o_arrived_at_target
);

    localparam int SUM_W = tfrp_pkg::QCNT_W + 1;

    // configuration
    logic [tfrp_pkg::POS_W-1:0]    r_floor_one;
    logic [tfrp_pkg::POS_W-1:0]    r_floor_two;
    logic [tfrp_pkg::POS_W-1:0]    r_floor_three;
    logic [tfrp_pkg::MARGIN_W-1:0] r_margin;

    // latched item
    logic [tfrp_pkg::KIND_W-1:0] r_kind;
    logic [tfrp_pkg::POS_W-1:0]  r_car;
    logic                        r_doors;

    // planner state
    logic [1:0]                  r_store [tfrp_pkg::QUEUE_DEPTH];
    logic [2:0]                  r_pending, n_pending;
    logic [tfrp_pkg::QIDX_W-1:0] r_head, n_head;
    logic [tfrp_pkg::QCNT_W-1:0] r_count, n_count;
    logic [tfrp_pkg::POS_W-1:0]  r_desired, n_desired;
    logic                        r_stop_held, n_stop_held;

    // result register
    logic                       r_valid;
    logic [tfrp_pkg::POS_W-1:0] r_out_target;
    logic                       r_out_update;
    logic                       r_out_stop;
    logic                       r_out_arrived;

    logic                        call;
    logic [1:0]                  call_code;
    logic [tfrp_pkg::POS_W-1:0]  call_pos;
    logic                        free_call;
    logic                        front_ok;
    logic                        not_full;
    logic                        push;
    logic [SUM_W-1:0]            tail_sum;
    logic [tfrp_pkg::QIDX_W-1:0] tail_idx;
    logic [tfrp_pkg::QIDX_W-1:0] front_idx;
    logic [tfrp_pkg::QIDX_W-1:0] wr_idx;
    logic [1:0]                  head_code;
    logic [tfrp_pkg::POS_W-1:0]  head_pos;
    logic                        arrival;

    function automatic logic [tfrp_pkg::POS_W-1:0] floor_pos(
        input logic [1:0]                 code,
        input logic [tfrp_pkg::POS_W-1:0] p_one,
        input logic [tfrp_pkg::POS_W-1:0] p_two,
        input logic [tfrp_pkg::POS_W-1:0] p_three
    );
        logic [tfrp_pkg::POS_W-1:0] pos;
        pos = p_three;
        if (code == tfrp_pkg::FLOOR_ONE) begin
            pos = p_one;
        end else if (code == tfrp_pkg::FLOOR_TWO) begin
            pos = p_two;
        end
        return pos;
    endfunction

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_one   <= tfrp_pkg::POS_W'(0);
            r_floor_two   <= tfrp_pkg::POS_W'(400);
            r_floor_three <= tfrp_pkg::POS_W'(800);
            r_margin      <= tfrp_pkg::MARGIN_W'(50);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfrp_pkg::CFG_FLOOR_ONE:   r_floor_one   <= i_cfg_data;
                tfrp_pkg::CFG_FLOOR_TWO:   r_floor_two   <= i_cfg_data;
                tfrp_pkg::CFG_FLOOR_THREE: r_floor_three <= i_cfg_data;
                tfrp_pkg::CFG_NEAR_MARGIN: r_margin <= i_cfg_data[tfrp_pkg::MARGIN_W-1:0];
                default:                   r_margin      <= r_margin;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_car   <= i_car_position;
            r_doors <= i_door_open;
        end
    end

    // event phase
    always_comb begin
        call      = (r_kind >= tfrp_pkg::KIND_CALL_ONE) && (r_kind <= tfrp_pkg::KIND_CALL_THREE);
        call_code = 2'(r_kind - tfrp_pkg::KIND_CALL_ONE);
        call_pos  = floor_pos(call_code, r_floor_one, r_floor_two, r_floor_three);
        free_call = call && !r_pending[call_code] && (r_car != call_pos);
        // middle call jumps the queue when the car is heading past it, far enough off
        front_ok  = (call_code == tfrp_pkg::FLOOR_TWO) &&
                    (((r_desired == r_floor_three) &&
                      (({1'b0, r_car} + 11'(r_margin)) < {1'b0, r_floor_two})) ||
                     ((r_desired == r_floor_one) &&
                      ({1'b0, r_car} > ({1'b0, r_floor_two} + 11'(r_margin)))));
        not_full  = r_count < tfrp_pkg::QCNT_W'(tfrp_pkg::QUEUE_DEPTH);
        push      = i_cmd.apply_event && free_call && not_full;
        tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(tfrp_pkg::QUEUE_DEPTH)) begin
            tail_idx = tfrp_pkg::QIDX_W'(tail_sum - SUM_W'(tfrp_pkg::QUEUE_DEPTH));
        end else begin
            tail_idx = tfrp_pkg::QIDX_W'(tail_sum);
        end
        if (r_head == '0) begin
            front_idx = tfrp_pkg::QIDX_W'(tfrp_pkg::QUEUE_DEPTH - 1);
        end else begin
            front_idx = r_head - 1'b1;
        end
        wr_idx = front_ok ? front_idx : tail_idx;
    end

    // serve phase
    always_comb begin
        head_code = r_store[r_head];
        head_pos  = floor_pos(head_code, r_floor_one, r_floor_two, r_floor_three);
        arrival   = i_cmd.serve && (r_car == head_pos);
    end

    always_comb begin
        n_pending   = r_pending;
        n_head      = r_head;
        n_count     = r_count;
        n_desired   = r_desired;
        n_stop_held = r_stop_held;
        if (i_cmd.apply_event) begin
            if (push) begin
                n_pending[call_code] = 1'b1;
                n_count              = r_count + 1'b1;
                if (front_ok) begin
                    n_head = front_idx;
                end
            end
            if (r_kind == tfrp_pkg::KIND_STOP_PRESS) begin
                n_stop_held = 1'b1;
            end else if (r_kind == tfrp_pkg::KIND_STOP_FREE) begin
                n_stop_held = 1'b0;
            end
        end
        if (i_cmd.serve) begin
            n_desired = head_pos;
        end
        if (arrival) begin
            n_pending[head_code] = 1'b0;
            n_count              = r_count - 1'b1;
            if (r_head == tfrp_pkg::QIDX_W'(tfrp_pkg::QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_desired   <= '0;
            r_stop_held <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_head      <= n_head;
            r_count     <= n_count;
            r_desired   <= n_desired;
            r_stop_held <= n_stop_held;
            r_valid     <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[wr_idx] <= call_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_target  <= n_desired;
            r_out_update  <= i_cmd.serve;
            r_out_stop    <= n_stop_held;
            r_out_arrived <= arrival;
        end
    end

    assign o_status.door_open      = r_doors;
    assign o_status.queue_nonempty = (r_count != '0);

    assign o_valid             = r_valid;
    assign o_target_position   = r_out_target;
    assign o_target_update     = r_out_update;
    assign o_motor_stop        = r_out_stop;
    assign o_arrived_at_target = r_out_arrived;

endmodule

// File: src/three_floor_request_planner_unit.sv
// o_valid is registered from the serve step: start is accepted in idle, then event step, serve step
// a new item is taken only back in idle, after the capture, event and serve steps of the sequencer
// busy is high from the accepting edge until the serve step is done
// the receiver cannot stall: each result is shown for one cycle only
// reset (i_rst_n low at a clock edge): queue empty, flags and stop clear, target zero,
//   floor positions 0 / 400 / 800 and margin 50
// ----------------------------------------------------------------------------
// three_floor_request_planner_unit
// request planner for a three floor lift car: queues floor calls, picks the
// target from the queue head, tracks the stop button and flags arrival
// ----------------------------------------------------------------------------
module three_floor_request_planner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item handshake
    input  logic                                start,
    output logic                                busy,
    input  logic [tfrp_pkg::KIND_W-1:0]         i_kind,
    input  logic [tfrp_pkg::POS_W-1:0]          i_car_position,
    input  logic                                i_door_open,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tfrp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tfrp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // result, one cycle per item
    output logic                                o_valid,
    output logic [tfrp_pkg::POS_W-1:0]          o_target_position,
    output logic                                o_target_update,
    output logic                                o_motor_stop,
    output logic                                o_arrived_at_target
);

    // commands from the sequencer, status back from the datapath
    tfrp_pkg::t_dp_cmd    cmd;
    tfrp_pkg::t_dp_status status;

    // sequencer: idle -> event -> serve -> idle
    tfrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath: event step queues a call (back, or front for a middle call
    // while passing) or updates the stop hold; serve step takes the head as
    // target and pops it on arrival
    tfrp_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_kind              (i_kind),
        .i_car_position      (i_car_position),
        .i_door_open         (i_door_open),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_target_position   (o_target_position),
        .o_target_update     (o_target_update),
        .o_motor_stop        (o_motor_stop),
        .o_arrived_at_target (o_arrived_at_target)
    );

endmodule

// File: src/tfrp_checker.sv
// ----------------------------------------------------------------------------
// tfrp_checker
// port-level checks of the request planner handshake and result timing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_target_update,
    input logic o_arrived_at_target
);

    // an accepted item makes the block busy
    `TFRP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result only follows a busy cycle
    `TFRP_ASSERT_IMPL(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    // results are spaced, never back to back
    `TFRP_ASSERT_NEXT(a_valid_spaced, i_clk, i_rst_n, o_valid, !o_valid)
    // arrival only on a step that issued a target
    `TFRP_ASSERT_IMPL(a_arrive_update, i_clk, i_rst_n, o_valid && o_arrived_at_target,
        o_target_update)

endmodule

bind three_floor_request_planner_unit tfrp_checker u_tfrp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_valid             (o_valid),
    .o_target_update     (o_target_update),
    .o_arrived_at_target (o_arrived_at_target)
);
